/* design/closest_point_on_triangle_unit_defines.svh */
// assertion macros shared by the closest point on triangle unit
`ifndef CLOSEST_POINT_ON_TRIANGLE_UNIT_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define CPT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CPT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cpt_pkg.sv */
// types, widths and codes of the closest point on triangle unit
package cpt_pkg;

  localparam int COORD_BITS      = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int CROSS_W = 2 * DOT_W + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;

  typedef enum logic [2:0] {
    REG_A     = 3'd0,
    REG_B     = 3'd1,
    REG_AB    = 3'd2,
    REG_C     = 3'd3,
    REG_AC    = 3'd4,
    REG_BC    = 3'd5,
    REG_FACE  = 3'd6,
    REG_DEGEN = 3'd7
  } region_t;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
  } in_item_t;

  typedef struct packed {
    coord_t     near_x;
    coord_t     near_y;
    coord_t     near_z;
    logic [2:0] region;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    region_t      code;
    coord_t [2:0] base;
    diff_t  [2:0] dir1;
    diff_t  [2:0] dir2;
    cross_t       num1;
    cross_t       num2;
    cross_t       den;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

/* design/cpt_front.sv */
// front pipeline: corner differences, dot products, cross terms, region classification
module cpt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  cpt_pkg::in_item_t in_item,
  output logic              push,
  output cpt_pkg::job_t     push_job
);
  import cpt_pkg::*;

  localparam int NSTG = 7;
  localparam int HALF = DOT_W / 2;
  localparam int HI_W = DOT_W - HALF;
  localparam int PP_W = 2 * (HI_W + 1);
  localparam int XP_W = 2 * DOT_W;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    diff_t  [2:0] ab;
    diff_t  [2:0] ac;
    diff_t  [2:0] bc;
  } geom_t;

  typedef struct packed {
    dot_t [5:0] d;
    cross_t     d13;
    cross_t     d26;
    cross_t     e43;
    cross_t     e56;
    cross_t     ebc;
  } mid_t;

  function automatic diff_t dsub(coord_t x, coord_t y);
    dsub = diff_t'(x) - diff_t'(y);
  endfunction

  logic [NSTG-1:0] v_r;
  geom_t           g_r [NSTG];
  diff_t [2:0]     ap_r, bp_r, cp_r;
  logic signed [PROD_W-1:0] m_r [6][3];
  dot_t            d_r [6];
  logic signed [PP_W-1:0]   pp_r [6][4];
  logic signed [XP_W-1:0]   x_r [6];
  mid_t            mid_r [4];
  cross_t          vx5_r [3];
  cross_t          vx6_r [3];
  cross_t          den_r;

  coord_t [2:0] p_c, a_c, b_c, c_c;
  diff_t  [2:0] lhs_c [6];
  diff_t  [2:0] rhs_c [6];
  dot_t         xa_c [6];
  dot_t         xb_c [6];

  assign p_c = {in_item.query_z, in_item.query_y, in_item.query_x};
  assign a_c = {in_item.corner_a_z, in_item.corner_a_y, in_item.corner_a_x};
  assign b_c = {in_item.corner_b_z, in_item.corner_b_y, in_item.corner_b_x};
  assign c_c = {in_item.corner_c_z, in_item.corner_c_y, in_item.corner_c_x};

  // d1..d6 operand pairs
  assign lhs_c = '{g_r[0].ab, g_r[0].ac, g_r[0].ab, g_r[0].ac, g_r[0].ab, g_r[0].ac};
  assign rhs_c = '{ap_r, ap_r, bp_r, bp_r, cp_r, cp_r};

  // d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  assign xa_c = '{d_r[0], d_r[2], d_r[4], d_r[0], d_r[2], d_r[4]};
  assign xb_c = '{d_r[3], d_r[1], d_r[1], d_r[5], d_r[5], d_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NSTG-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: differences
    for (int i = 0; i < 3; i++) begin
      g_r[0].a[i]  <= a_c[i];
      g_r[0].b[i]  <= b_c[i];
      g_r[0].c[i]  <= c_c[i];
      g_r[0].ab[i] <= dsub(b_c[i], a_c[i]);
      g_r[0].ac[i] <= dsub(c_c[i], a_c[i]);
      g_r[0].bc[i] <= dsub(c_c[i], b_c[i]);
      ap_r[i]      <= dsub(p_c[i], a_c[i]);
      bp_r[i]      <= dsub(p_c[i], b_c[i]);
      cp_r[i]      <= dsub(p_c[i], c_c[i]);
    end
    for (int s = 1; s < NSTG; s++) begin
      g_r[s] <= g_r[s-1];
    end
    // stage 1: component products
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        m_r[k][i] <= $signed(lhs_c[k][i]) * $signed(rhs_c[k][i]);
      end
    end
    // stage 2: dot products
    for (int k = 0; k < 6; k++) begin
      d_r[k] <= dot_t'(m_r[k][0]) + dot_t'(m_r[k][1]) + dot_t'(m_r[k][2]);
    end
    // stage 3: split cross products into half-width partials, edge spans
    for (int j = 0; j < 6; j++) begin
      pp_r[j][0] <= $signed(xa_c[j][DOT_W-1:HALF]) * $signed(xb_c[j][DOT_W-1:HALF]);
      pp_r[j][1] <= $signed(xa_c[j][DOT_W-1:HALF]) * $signed({1'b0, xb_c[j][HALF-1:0]});
      pp_r[j][2] <= $signed({1'b0, xa_c[j][HALF-1:0]}) * $signed(xb_c[j][DOT_W-1:HALF]);
      pp_r[j][3] <= $signed({1'b0, xa_c[j][HALF-1:0]}) * $signed({1'b0, xb_c[j][HALF-1:0]});
    end
    for (int k = 0; k < 6; k++) begin
      mid_r[0].d[k] <= d_r[k];
    end
    mid_r[0].d13 <= cross_t'(d_r[0]) - cross_t'(d_r[2]);
    mid_r[0].d26 <= cross_t'(d_r[1]) - cross_t'(d_r[5]);
    mid_r[0].e43 <= cross_t'(d_r[3]) - cross_t'(d_r[2]);
    mid_r[0].e56 <= cross_t'(d_r[4]) - cross_t'(d_r[5]);
    mid_r[0].ebc <= cross_t'(d_r[3]) - cross_t'(d_r[2]) + cross_t'(d_r[4])
                    - cross_t'(d_r[5]);
    for (int s = 1; s < 4; s++) begin
      mid_r[s] <= mid_r[s-1];
    end
    // stage 4: recombine partials
    for (int j = 0; j < 6; j++) begin
      x_r[j] <= (XP_W'(pp_r[j][0]) <<< (2 * HALF))
              + ((XP_W'(pp_r[j][1]) + XP_W'(pp_r[j][2])) <<< HALF)
              + XP_W'(pp_r[j][3]);
    end
    // stage 5: vc, vb, va
    vx5_r[0] <= cross_t'(x_r[0]) - cross_t'(x_r[1]);
    vx5_r[1] <= cross_t'(x_r[2]) - cross_t'(x_r[3]);
    vx5_r[2] <= cross_t'(x_r[4]) - cross_t'(x_r[5]);
    // stage 6: face denominator
    vx6_r <= vx5_r;
    den_r <= vx5_r[0] + vx5_r[1] + vx5_r[2];
  end

  // region classification off stage 6
  always_comb begin
    mid_t  m;
    geom_t g;
    job_t  j;
    m = mid_r[3];
    g = g_r[NSTG-1];
    j.code = REG_A;
    j.base = g.a;
    j.dir1 = g.ab;
    j.dir2 = g.ac;
    j.num1 = '0;
    j.num2 = '0;
    j.den  = '0;
    if (m.d[0] <= 0 && m.d[1] <= 0) begin
      j.code = REG_A;
    end else if (m.d[2] >= 0 && m.d[3] <= m.d[2]) begin
      j.code = REG_B;
      j.base = g.b;
    end else if (vx6_r[0] <= 0 && m.d[0] >= 0 && m.d[2] <= 0) begin
      j.code = REG_AB;
      j.num1 = cross_t'(m.d[0]);
      j.den  = m.d13;
    end else if (m.d[5] >= 0 && m.d[4] <= m.d[5]) begin
      j.code = REG_C;
      j.base = g.c;
    end else if (vx6_r[1] <= 0 && m.d[1] >= 0 && m.d[5] <= 0) begin
      j.code = REG_AC;
      j.dir1 = g.ac;
      j.num1 = cross_t'(m.d[1]);
      j.den  = m.d26;
    end else if (vx6_r[2] <= 0 && m.e43 >= 0 && m.e56 >= 0) begin
      j.code = REG_BC;
      j.base = g.b;
      j.dir1 = g.bc;
      j.num1 = m.e43;
      j.den  = m.ebc;
    end else if (den_r <= 0) begin
      j.code = REG_DEGEN;
    end else begin
      j.code = REG_FACE;
      j.num1 = vx6_r[1];
      j.num2 = vx6_r[0];
      j.den  = den_r;
    end
    push_job = j;
  end

  assign push = v_r[NSTG-1];

endmodule

/* design/cpt_queue.sv */
// job queue between front and back
module cpt_queue #(
  parameter int DEPTH = cpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cpt_pkg::job_t   push_job,
  input  logic            pop,
  output cpt_pkg::job_t   head,
  output cpt_pkg::qstat_t stat
);
  import cpt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

  assign head       = mem[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));

endmodule

/* design/cpt_back.sv */
// back end: ratio divider, interpolation and saturation
module cpt_back #(
  parameter int FRAC_BITS = cpt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cpt_pkg::qstat_t    qstat,
  input  cpt_pkg::job_t      head,
  output logic               pop,
  output logic               out_strobe,
  output cpt_pkg::out_item_t out_item
);
  import cpt_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam int MW    = DIFF_W + FRAC_BITS + 2;
  localparam int SW    = MW + 1;
  localparam int VW    = SW + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [VW-1:0] VMAX =
    {{(VW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN =
    {{(VW - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SUM  = 4'b1000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  region_t              code_r;
  coord_t [2:0]         base_r;
  diff_t  [2:0]         dir_r [2];
  logic [CROSS_W-1:0]   den_r;
  logic [CROSS_W-1:0]   rem_r [2];
  logic [FRAC_BITS:0]   q_r [2];
  logic [1:0]           act_r;
  logic signed [MW-1:0] p_r [2][3];
  logic                 out_v_r;
  out_item_t            out_r;

  logic [FRAC_BITS:0]   q_init [2];
  logic [1:0]           act_init;
  logic [CROSS_W-1:0]   t_c [2];
  logic [1:0]           ge_c;
  coord_t [2:0]         near_c;

  // lane set-up: zero, exactly one, or divide
  always_comb begin
    cross_t num;
    logic   zero;
    logic   one;
    for (int l = 0; l < 2; l++) begin
      num         = (l == 0) ? head.num1 : head.num2;
      zero        = (num <= 0) || (head.den <= 0);
      one         = !zero && (num >= head.den);
      q_init[l]   = one ? ONE : '0;
      act_init[l] = !zero && !one;
    end
  end

  // one restoring step per lane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t_c[l]  = {rem_r[l][CROSS_W-2:0], 1'b0};
      ge_c[l] = (t_c[l] >= den_r);
    end
  end

  assign pop = ((state_r == ST_IDLE) || (state_r == ST_SUM)) && !qstat.empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_SUM: begin
        if (!qstat.empty) begin
          state_nxt = (act_init != 2'b00) ? ST_DIV : ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_SUM;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= (state_r == ST_SUM);
      if (pop) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r   <= head.code;
      base_r   <= head.base;
      dir_r[0] <= head.dir1;
      dir_r[1] <= head.dir2;
      den_r    <= head.den;
      rem_r[0] <= head.num1;
      rem_r[1] <= head.num2;
      q_r      <= q_init;
      act_r    <= act_init;
    end else if (state_r == ST_DIV) begin
      for (int l = 0; l < 2; l++) begin
        if (act_r[l]) begin
          rem_r[l] <= ge_c[l] ? t_c[l] - den_r : t_c[l];
          q_r[l]   <= {q_r[l][FRAC_BITS-1:0], ge_c[l]};
        end
      end
    end
    if (state_r == ST_MUL) begin
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < 3; i++) begin
          p_r[l][i] <= $signed(dir_r[l][i]) * $signed({1'b0, q_r[l]});
        end
      end
    end
  end

  // base plus floored offset, clamped to the coordinate range
  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] sh;
    logic signed [VW-1:0] val;
    for (int i = 0; i < 3; i++) begin
      s   = SW'(p_r[0][i]) + SW'(p_r[1][i]);
      sh  = s >>> FRAC_BITS;
      val = VW'(base_r[i]) + VW'(sh);
      if (val > VMAX) begin
        val = VMAX;
      end else if (val < VMIN) begin
        val = VMIN;
      end
      near_c[i] = val[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      out_r.near_x <= near_c[0];
      out_r.near_y <= near_c[1];
      out_r.near_z <= near_c[2];
      out_r.region <= code_r;
    end
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

endmodule

/* design/closest_point_on_triangle_unit.sv */
// top level of the closest point on triangle unit
//
//   channel   handshake             payload
//   input     start / busy          in_item  (query point and corners a, b, c)
//   result    out_strobe            out_item (nearest point and region code)
//
// a beat enters through a seven stage front pipeline (differences, dot
// products, split cross products, classification), waits in a job queue,
// then a back end interpolates it
// the back end takes one beat at a time: vertex and degenerate beats go
// from the queue to its multiply and sum states; edge and face beats whose
// ratio lies strictly between zero and one first pass the one bit per
// cycle ratio divider (both face ratios share its steps)
// busy rises when QUEUE_DEPTH beats are held between acceptance and the back
// end; results cannot be held off, so the back end never waits on output
// synchronous active-low reset clears valids, credits and the back end state
`include "closest_point_on_triangle_unit_defines.svh"

module closest_point_on_triangle_unit #(
  parameter int FRAC_BITS   = cpt_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = cpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cpt_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output cpt_pkg::out_item_t out_item
);
  import cpt_pkg::*;

  localparam int HW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;
  qstat_t        qstat;
  // beats accepted and not yet taken by the back end
  logic [HW-1:0] held_r;

  assign busy   = (held_r == HW'(QUEUE_DEPTH));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_r + HW'(accept) - HW'(pop);
    end
  end

  // classification pipeline
  cpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (accept),
    .in_item  (in_item),
    .push     (push),
    .push_job (push_job)
  );

  // decoupling queue, sized by the credit count above
  cpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  // divider and interpolation
  cpt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  `CPT_NEVER(a_push_full, push && qstat.full, "job pushed into a full queue")
  `CPT_NEVER(a_pop_empty, pop && qstat.empty, "job popped from an empty queue")
  `CPT_NEXT(a_credit_up, accept && !pop, held_r == $past(held_r) + 1'b1, "credit count lost a beat")

endmodule
